/* src/bmo_pkg.sv */
`default_nettype none

package bmo_pkg;

    // Waveform codes
    localparam logic [2:0] WF_SAW      = 3'd0;
    localparam logic [2:0] WF_SQUARE   = 3'd1;
    localparam logic [2:0] WF_NOISE    = 3'd2;
    localparam logic [2:0] WF_TRIANGLE = 3'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_WAVEFORM    = 2'd0;
    localparam logic [1:0] CFG_PHASE_STEP  = 2'd1;
    localparam logic [1:0] CFG_PULSE_WIDTH = 2'd2;

    // Silence threshold on the block target
    localparam logic [15:0] AMP_FLOOR = 16'd66;

    // Park-Miller generator
    localparam logic [14:0] PM_A = 15'd16807;
    localparam logic [31:0] PM_M = 32'h7fff_ffff;

    // Status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

`default_nettype wire

/* src/bandlimited_multiwave_oscillator.sv */
`default_nettype none

// Phase-accumulator oscillator with saw, square, triangle and held noise.
// Input stream (s_axis): one transaction per sample tick, carrying the block
//   target amplitude and length in tdata and the block-start flag in tuser.
// Output stream (m_axis): one transaction per tick, the saturated sample in
//   tdata and the active flag in tuser (sample is zero when inactive).
// Configuration: cfg_we/cfg_index/cfg_data write waveform, phase step and
//   pulse width; write only while no tick is in progress.
// Each tick is worked one at a time. A silent tick passes through accept,
// decide and commit. An audible one adds a phase step and a scaling multiply
// (a held noise sample skips the multiply). A block start adds a ramp divide,
// a wrap edge that needs blending a divide, the saw blend a multiply and a
// noise draw another. These use the shared divider (one quotient bit per
// cycle) and multiplier (one bit per cycle).
// The output register lets the next tick be taken while a result waits; a
// finished tick holds in its last step until the receiver frees the register.
// Reset: phase, ramp and noise clear, the seed goes to one, the oscillator is
// silent until the first block start, and the output stream empties.

module bandlimited_multiwave_oscillator
    import bmo_pkg::*;
#(
    parameter int PHASE_FRAC_BITS = 24,
    parameter int MAX_BLOCK       = 4096,
    parameter int SAMPLE_BITS     = 16
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // [15:0] target_amp, [28:16] block_length, [31:29] zero
    input  wire logic [31:0]                s_axis_tdata,
    // [0] block_start
    input  wire logic                       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // [SAMPLE_BITS-1:0] sample, zero fill above
    output logic [((SAMPLE_BITS+7)/8)*8-1:0] m_axis_tdata,
    // [0] active
    output logic                            m_axis_tuser,
    input  wire logic                       cfg_we,
    input  wire logic [1:0]                 cfg_index,
    input  wire logic [PHASE_FRAC_BITS:0]   cfg_data
);

    localparam int F   = PHASE_FRAC_BITS;
    localparam int SB  = SAMPLE_BITS;
    localparam int PB  = F + 3;
    localparam int RW  = F + 1;
    localparam int VW  = F + 4;
    localparam int WW  = F + 5;
    localparam int AW  = (VW > 32) ? VW : 32;
    localparam int BW  = (F + 1 > 16) ? F + 1 : 16;
    localparam int PW  = AW + BW + 1;
    localparam int NW  = (2 * F + 1 > 32) ? 2 * F + 1 : 32;
    localparam int DVW = F + 1;
    localparam int SS  = F + 16 - (SB - 1);
    localparam int OBW = ((SB + 7) / 8) * 8;
    localparam int LEN_MAX = (MAX_BLOCK > 8191) ? 8191 : MAX_BLOCK;

    localparam longint ONE_L  = longint'(1) << F;
    localparam longint STEP_L = (19 * ONE_L) / 10;
    localparam longint PW_L   = (9 * ONE_L) / 10;

    localparam logic signed [WW-1:0] ONE_W    = WW'(ONE_L);
    localparam logic        [RW-1:0] STEP_MAX = RW'(STEP_L);
    localparam logic signed [RW-1:0] PW_MAX   = RW'(PW_L);
    localparam logic signed [RW-1:0] PW_MIN   = -RW'(PW_L);
    localparam logic signed [PW-1:0] SMP_MAX  = PW'((longint'(1) << (SB - 1)) - 1);
    localparam logic signed [PW-1:0] SMP_MIN  = -PW'((longint'(1) << (SB - 1)));

    typedef enum logic [3:0] {
        S_IDLE, S_START, S_RDIV, S_PHASE, S_ADIV, S_BLEND, S_BLENDW,
        S_NMUL, S_SCALE, S_SCALEW, S_DONE
    } state_t;

    // Configuration registers
    logic [2:0]           waveform_reg;
    logic [RW-1:0]        step_reg;
    logic signed [RW-1:0] pw_reg;

    // Oscillator state
    logic signed [PB-1:0] phase_reg;
    logic [15:0]          from_amp_reg;
    logic [31:0]          ramp_amp_reg;
    logic signed [32:0]   ramp_step_reg;
    logic                 silent_reg;
    logic                 edge_pulse_reg;
    logic                 sq_sign_reg;
    logic signed [SB-1:0] noise_hold_reg;
    logic [30:0]          seed_reg;

    // Per-tick working registers
    state_t               state_reg;
    logic [15:0]          tgt_reg;
    logic [12:0]          len_reg;
    logic                 start_reg;
    logic signed [PB-1:0] p_next_reg;
    logic                 hit_reg;
    logic [F:0]           red_reg;
    logic signed [VW-1:0] v_reg;
    logic                 is_noise_reg;
    logic                 neg_reg;
    logic [SB-1:0]        res_sample_reg;
    logic                 res_active_reg;

    // Output register
    logic                 out_valid_reg;
    logic [SB-1:0]        out_sample_reg;
    logic                 out_active_reg;

    // Serial units and their requests
    logic                 div_go_reg;
    logic [NW-1:0]        div_a_reg;
    logic [DVW-1:0]       div_b_reg;
    logic [NW-1:0]        div_q;
    unit_stat_t           div_stat;
    logic                 mul_go_reg;
    logic signed [AW-1:0] mul_a_reg;
    logic [BW-1:0]        mul_b_reg;
    logic signed [PW-1:0] mul_p;
    unit_stat_t           mul_stat;

    // Combinational terms
    logic signed [WW-1:0] step_w;
    logic signed [WW-1:0] ps_w;
    logic signed [WW-1:0] lim_w;
    logic signed [WW-1:0] over_w;
    logic                 hit_w;
    logic                 red_full_w;
    logic signed [WW-1:0] p_next_w;
    logic signed [VW-1:0] ph_v;
    logic signed [VW-1:0] ph_neg;
    logic signed [VW-1:0] tri_v;
    logic signed [VW-1:0] sq_flat_v;
    logic signed [VW-1:0] sq_edge_v;
    logic signed [VW-1:0] blend_v;
    logic signed [PW-1:0] blend_term;
    logic                 silent_new;
    logic                 quiet;
    logic [12:0]          len_c;
    logic [16:0]          amp_diff;
    logic [15:0]          amp_mag;
    logic [31:0]          pm_fold;
    logic [30:0]          seed_new;
    logic signed [31:0]   noise_r;
    logic signed [33:0]   ramp_sum;
    logic signed [33:0]   ramp_tgt;
    logic [31:0]          ramp_new;
    logic                 out_free;

    function automatic logic [SB-1:0] saturate(input logic signed [PW-1:0] p);
        logic signed [PW-1:0] sh;
        sh = p >>> SS;
        if (sh > SMP_MAX)
            sh = SMP_MAX;
        else if (sh < SMP_MIN)
            sh = SMP_MIN;
        return sh[SB-1:0];
    endfunction

    bmo_div #(.NW(NW), .DVW(DVW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .quotient (div_q),
        .stat     (div_stat)
    );

    bmo_mul #(.AW(AW), .BW(BW)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (mul_go_reg),
        .a     (mul_a_reg),
        .b     (mul_b_reg),
        .prod  (mul_p),
        .stat  (mul_stat)
    );

    always_comb
    begin
        // Block start decision
        silent_new = (tgt_reg < AMP_FLOOR) || (waveform_reg > WF_TRIANGLE);
        quiet      = start_reg ? silent_new : (silent_reg || (waveform_reg > WF_TRIANGLE));
        if (len_reg == 13'd0)
            len_c = 13'd1;
        else if (32'(len_reg) > 32'(LEN_MAX))
            len_c = 13'(LEN_MAX);
        else
            len_c = len_reg;
        amp_diff = {1'b0, tgt_reg} - {1'b0, from_amp_reg};
        amp_mag  = amp_diff[16] ? 16'(-amp_diff) : amp_diff[15:0];

        // Phase advance and wrap test; saw wraps above ONE - step/2
        step_w = WW'($signed({1'b0, step_reg}));
        ps_w   = WW'(phase_reg) + step_w;
        if (waveform_reg == WF_SAW)
            lim_w = ONE_W - WW'($signed({2'b0, step_reg[RW-1:1]}));
        else if ((waveform_reg == WF_SQUARE) && edge_pulse_reg)
            lim_w = WW'(pw_reg);
        else
            lim_w = ONE_W;
        hit_w      = ps_w > lim_w;
        over_w     = ps_w - lim_w;
        red_full_w = over_w >= step_w;
        if (hit_w && !((waveform_reg == WF_SQUARE) && edge_pulse_reg))
            p_next_w = ps_w - (ONE_W <<< 1);
        else
            p_next_w = ps_w;

        // Triangle from the current phase
        ph_v   = VW'(phase_reg);
        ph_neg = (ph_v > 0) ? -ph_v : ph_v;
        tri_v  = (ph_neg <<< 1) + VW'(ONE_W);

        // Square levels: flat, and edge blended by ONE - 2*red
        sq_flat_v = sq_sign_reg ? -VW'(ONE_W) : VW'(ONE_W);
        sq_edge_v = VW'(ONE_W) - VW'($signed({1'b0, div_q[F:0], 1'b0}));
        if (sq_sign_reg)
            sq_edge_v = -sq_edge_v;

        // Saw blend: prev + floor(red * (step - 2*ONE) / ONE)
        blend_term = mul_p >>> F;
        blend_v    = ph_v + VW'(blend_term);

        // Park-Miller by folding the product modulo 2^31 - 1
        pm_fold  = {1'b0, mul_p[30:0]} + 32'(mul_p[45:31]);
        seed_new = (pm_fold >= PM_M) ? 31'(pm_fold - PM_M) : pm_fold[30:0];
        noise_r  = $signed({1'b0, seed_new}) - 32'sh4000_0000;

        // Amplitude ramp, never past the target
        ramp_sum = $signed({2'b0, ramp_amp_reg}) + 34'(ramp_step_reg);
        ramp_tgt = $signed({2'b0, from_amp_reg, 16'b0});
        if ((ramp_step_reg > 0) && (ramp_sum > ramp_tgt))
            ramp_new = ramp_tgt[31:0];
        else if ((ramp_step_reg < 0) && (ramp_sum < ramp_tgt))
            ramp_new = ramp_tgt[31:0];
        else
            ramp_new = ramp_sum[31:0];

        out_free = !out_valid_reg || m_axis_tready;
    end

    // Configuration writes; phase step and pulse width are clamped on entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg <= WF_SAW;
            step_reg     <= RW'(7398);
            pw_reg       <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAVEFORM:
                    waveform_reg <= cfg_data[2:0];
                CFG_PHASE_STEP:
                    step_reg <= (cfg_data > STEP_MAX) ? STEP_MAX : cfg_data;
                CFG_PULSE_WIDTH:
                begin
                    if ($signed(cfg_data) > PW_MAX)
                        pw_reg <= PW_MAX;
                    else if ($signed(cfg_data) < PW_MIN)
                        pw_reg <= PW_MIN;
                    else
                        pw_reg <= $signed(cfg_data);
                end
                default:
                    ;
            endcase
        end
    end

    // Tick sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= '0;
            from_amp_reg   <= '0;
            ramp_amp_reg   <= '0;
            ramp_step_reg  <= '0;
            silent_reg     <= 1'b1;
            edge_pulse_reg <= 1'b0;
            sq_sign_reg    <= 1'b0;
            noise_hold_reg <= '0;
            seed_reg       <= 31'd1;
            out_valid_reg  <= 1'b0;
            div_go_reg     <= 1'b0;
            mul_go_reg     <= 1'b0;
            tgt_reg        <= '0;
            len_reg        <= '0;
            start_reg      <= 1'b0;
            p_next_reg     <= '0;
            hit_reg        <= 1'b0;
            red_reg        <= '0;
            v_reg          <= '0;
            is_noise_reg   <= 1'b0;
            neg_reg        <= 1'b0;
            res_sample_reg <= '0;
            res_active_reg <= 1'b0;
            out_sample_reg <= '0;
            out_active_reg <= 1'b0;
            div_a_reg      <= '0;
            div_b_reg      <= '0;
            mul_a_reg      <= '0;
            mul_b_reg      <= '0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            mul_go_reg <= 1'b0;
            // Drop the sent transaction unless a new one is loaded this cycle
            if (m_axis_tready && !((state_reg == S_DONE) && out_free))
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        tgt_reg      <= s_axis_tdata[15:0];
                        len_reg      <= s_axis_tdata[28:16];
                        start_reg    <= s_axis_tuser;
                        is_noise_reg <= 1'b0;
                        hit_reg      <= 1'b0;
                        state_reg    <= S_START;
                    end
                end

                S_START:
                begin
                    if (start_reg)
                    begin
                        silent_reg <= silent_new;
                        if (!silent_new)
                        begin
                            ramp_amp_reg <= {from_amp_reg, 16'b0};
                            from_amp_reg <= tgt_reg;
                            if (waveform_reg == WF_SQUARE)
                                sq_sign_reg <= edge_pulse_reg;
                            neg_reg    <= amp_diff[16];
                            div_a_reg  <= NW'({amp_mag, 16'b0});
                            div_b_reg  <= DVW'(len_c);
                            div_go_reg <= 1'b1;
                        end
                    end
                    if (quiet)
                    begin
                        res_sample_reg <= '0;
                        res_active_reg <= 1'b0;
                        state_reg      <= S_DONE;
                    end
                    else if (start_reg)
                        state_reg <= S_RDIV;
                    else
                        state_reg <= S_PHASE;
                end

                S_RDIV:
                begin
                    if (div_stat.done)
                    begin
                        ramp_step_reg <= neg_reg ? -$signed({1'b0, div_q[31:0]})
                                                 : $signed({1'b0, div_q[31:0]});
                        state_reg     <= S_PHASE;
                    end
                end

                S_PHASE:
                begin
                    hit_reg        <= hit_w;
                    p_next_reg     <= PB'(p_next_w);
                    res_active_reg <= 1'b1;
                    red_reg        <= (F+1)'(ONE_L);
                    priority if (waveform_reg == WF_TRIANGLE)
                    begin
                        v_reg     <= tri_v;
                        state_reg <= S_SCALE;
                    end
                    else if (waveform_reg == WF_NOISE)
                    begin
                        if (hit_w)
                        begin
                            mul_a_reg  <= AW'($signed({1'b0, seed_reg}));
                            mul_b_reg  <= BW'(PM_A);
                            mul_go_reg <= 1'b1;
                            state_reg  <= S_NMUL;
                        end
                        else
                        begin
                            res_sample_reg <= noise_hold_reg;
                            state_reg      <= S_DONE;
                        end
                    end
                    else if (!hit_w)
                    begin
                        v_reg     <= (waveform_reg == WF_SAW) ? VW'(ps_w) : sq_flat_v;
                        state_reg <= S_SCALE;
                    end
                    else if (!red_full_w)
                    begin
                        // Blend factor over * ONE / step, below ONE here
                        div_a_reg  <= NW'({over_w[F:0], {F{1'b0}}});
                        div_b_reg  <= step_reg;
                        div_go_reg <= 1'b1;
                        state_reg  <= S_ADIV;
                    end
                    else if (waveform_reg == WF_SAW)
                        state_reg <= S_BLEND;
                    else
                    begin
                        // Full blend: the edge level is already the new sign
                        v_reg     <= -sq_flat_v;
                        state_reg <= S_SCALE;
                    end
                end

                S_ADIV:
                begin
                    if (div_stat.done)
                    begin
                        red_reg <= div_q[F:0];
                        if (waveform_reg == WF_SAW)
                            state_reg <= S_BLEND;
                        else
                        begin
                            v_reg     <= sq_edge_v;
                            state_reg <= S_SCALE;
                        end
                    end
                end

                S_BLEND:
                begin
                    mul_a_reg  <= AW'(step_w - (ONE_W <<< 1));
                    mul_b_reg  <= BW'(red_reg);
                    mul_go_reg <= 1'b1;
                    state_reg  <= S_BLENDW;
                end

                S_BLENDW:
                begin
                    if (mul_stat.done)
                    begin
                        v_reg     <= blend_v;
                        state_reg <= S_SCALE;
                    end
                end

                S_NMUL:
                begin
                    if (mul_stat.done)
                    begin
                        seed_reg     <= seed_new;
                        v_reg        <= VW'(noise_r >>> (30 - F));
                        is_noise_reg <= 1'b1;
                        state_reg    <= S_SCALE;
                    end
                end

                S_SCALE:
                begin
                    mul_a_reg  <= AW'(v_reg);
                    mul_b_reg  <= BW'(ramp_amp_reg[31:16]);
                    mul_go_reg <= 1'b1;
                    state_reg  <= S_SCALEW;
                end

                S_SCALEW:
                begin
                    if (mul_stat.done)
                    begin
                        res_sample_reg <= saturate(mul_p);
                        if (is_noise_reg)
                            noise_hold_reg <= $signed(saturate(mul_p));
                        state_reg <= S_DONE;
                    end
                end

                S_DONE:
                begin
                    // Hold until the output register is free, then commit the tick
                    if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_sample_reg <= res_sample_reg;
                        out_active_reg <= res_active_reg;
                        if (res_active_reg)
                        begin
                            phase_reg    <= p_next_reg;
                            ramp_amp_reg <= ramp_new;
                            if ((waveform_reg == WF_SQUARE) && hit_reg)
                            begin
                                sq_sign_reg    <= !sq_sign_reg;
                                edge_pulse_reg <= !edge_pulse_reg;
                            end
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OBW'(out_sample_reg);
    assign m_axis_tuser  = out_active_reg;

endmodule

`default_nettype wire

/* src/bmo_div.sv */
`default_nettype none

module bmo_div
    import bmo_pkg::*;
#(
    parameter int NW  = 49,
    parameter int DVW = 25
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           go,
    input  wire logic [NW-1:0]  dividend,
    input  wire logic [DVW-1:0] divisor,
    output logic      [NW-1:0]  quotient,
    output unit_stat_t          stat
);

    localparam int CW = $clog2(NW + 1);

    logic [DVW-1:0] rem_reg;
    logic [NW-1:0]  q_reg;
    logic [DVW-1:0] dvs_reg;
    logic [CW-1:0]  cnt_reg;
    logic           busy_reg;
    logic           done_reg;

    logic [DVW:0]   trial;
    logic [DVW:0]   diff;
    logic           ge;

    // One quotient bit per cycle, restoring
    always_comb
    begin
        trial = {rem_reg, q_reg[NW-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = trial >= {1'b0, dvs_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(NW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rem_reg <= '0;
            q_reg   <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[DVW-1:0] : trial[DVW-1:0];
            q_reg   <= {q_reg[NW-2:0], ge};
        end
    end

    assign quotient  = q_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

/* src/bmo_mul.sv */
`default_nettype none

module bmo_mul
    import bmo_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 25
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    go,
    input  wire logic signed [AW-1:0]    a,
    input  wire logic        [BW-1:0]    b,
    output logic signed [AW+BW:0]        prod,
    output unit_stat_t                   stat
);

    localparam int CW = $clog2(BW + 1);

    logic signed [AW:0]   hi_reg;
    logic        [BW-1:0] lo_reg;
    logic signed [AW:0]   a_reg;
    logic        [CW-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic signed [AW:0]   sum;

    // Add the multiplicand on each set multiplier bit, then shift right
    always_comb
    begin
        sum = hi_reg + (lo_reg[0] ? a_reg : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            hi_reg <= '0;
            lo_reg <= b;
            a_reg  <= (AW+1)'(a);
        end
        else if (busy_reg)
        begin
            hi_reg <= sum >>> 1;
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign prod      = {hi_reg, lo_reg};
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire
